FILE: design/rbd_pkg.sv
// ============================================================================
// rbd_pkg
// Shared types, sizes and codes for the ring buffer deque block.
// ============================================================================
`default_nettype none

package rbd_pkg;

    // Store geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = CNT_W + 1;

    // Request and response field widths
    localparam int FUNC_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int OCNT_W = 5;
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_READ_AT    = 3'd4,
        FN_INSERT_AT  = 3'd5,
        FN_REMOVE_AT  = 3'd6
    } t_func;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Store address sources, as logical offsets from the head
    typedef enum logic [2:0] {
        AS_HEAD_M1,
        AS_HEAD,
        AS_COUNT,
        AS_COUNT_M1,
        AS_POS,
        AS_CUR,
        AS_CUR_M1,
        AS_CUR_P1
    } t_asel;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [VAL_W-1:0]  data_out;
        logic [OCNT_W-1:0] count;
        logic [VAL_W-1:0]  front_value;
        logic [VAL_W-1:0]  back_value;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic    latch_req;
        logic    set_status;
        t_status status;
        logic    mem_we;
        t_asel   waddr_sel;
        logic    wdata_rd;
        t_asel   raddr_sel;
        logic    head_dec;
        logic    head_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    cur_load_count;
        logic    cur_load_pos;
        logic    cur_dec;
        logic    cur_inc;
        logic    data_from_front;
        logic    data_from_back;
        logic    data_from_rd;
        logic    front_from_rd;
        logic    back_from_rd;
        logic    load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              empty;
        logic              full;
        logic              pos_lt_count;
        logic              pos_le_count;
        logic              cur_gt_pos;
        logic              cur_p1_lt_count;
        logic              out_free;
    } t_stat;

endpackage

`default_nettype wire

FILE: design/rbd_datapath.sv
// ============================================================================
// rbd_datapath
// Circular element store, head and count registers, shift cursor and the
// response register.
// ============================================================================
`default_nettype none

module rbd_datapath import rbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_in_req,
    input  wire t_cmd i_cmd,
    input  wire logic i_out_stall,
    output t_stat     o_stat,
    output logic      o_out_valid,
    output t_rsp      o_out_rsp
);

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;
    t_req                  r_req;
    logic [IDX_W-1:0]      r_head;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_cur;
    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] r_front;
    logic [DATA_WIDTH-1:0] r_back;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic [IDX_W-1:0]      w_waddr;
    logic [IDX_W-1:0]      w_raddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [IDX_W-1:0]      w_head_m1;
    logic [IDX_W-1:0]      w_head_p1;
    logic [CMP_W-1:0]      w_pos_cmp;
    logic [CMP_W-1:0]      w_cnt_cmp;
    logic [CMP_W-1:0]      w_cur_cmp;
    logic                  w_out_free;

    // Map a logical offset from the head onto a store slot
    function automatic logic [IDX_W-1:0] slot_of(input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(r_head) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

    function automatic logic [IDX_W-1:0] addr_of(input t_asel sel);
        logic [IDX_W-1:0] a;
        case (sel)
            AS_HEAD_M1:  a = w_head_m1;
            AS_HEAD:     a = r_head;
            AS_COUNT:    a = slot_of(r_count);
            AS_COUNT_M1: a = slot_of(r_count - CNT_W'(1));
            AS_POS:      a = slot_of(CNT_W'(r_req.position));
            AS_CUR:      a = slot_of(r_cur);
            AS_CUR_M1:   a = slot_of(r_cur - CNT_W'(1));
            AS_CUR_P1:   a = slot_of(r_cur + CNT_W'(1));
            default:     a = r_head;
        endcase
        return a;
    endfunction

    // Wrap the head index in both directions
    assign w_head_m1 = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - IDX_W'(1);
    assign w_head_p1 = (r_head == IDX_W'(CAPACITY - 1)) ? '0 : r_head + IDX_W'(1);

    // Select store addresses
    always_comb begin
        w_waddr = addr_of(i_cmd.waddr_sel);
        w_raddr = addr_of(i_cmd.raddr_sel);
    end

    assign w_wdata = i_cmd.wdata_rd ? r_rdata : DATA_WIDTH'(r_req.value);

    // Compare position, cursor and count at a common width
    assign w_pos_cmp  = CMP_W'(r_req.position);
    assign w_cnt_cmp  = CMP_W'(r_count);
    assign w_cur_cmp  = CMP_W'(r_cur);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.func            = r_req.func;
        o_stat.empty           = (r_count == '0);
        o_stat.full            = (r_count >= CNT_W'(CAPACITY));
        o_stat.pos_lt_count    = (w_pos_cmp < w_cnt_cmp);
        o_stat.pos_le_count    = (w_pos_cmp <= w_cnt_cmp);
        o_stat.cur_gt_pos      = (w_cur_cmp > w_pos_cmp);
        o_stat.cur_p1_lt_count = ({1'b0, r_cur} + SUM_W'(1)) < {1'b0, r_count};
        o_stat.out_free        = w_out_free;
    end

    // Store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // Head, count and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.head_dec) begin
                r_head <= w_head_m1;
            end else if (i_cmd.head_inc) begin
                r_head <= w_head_p1;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request, cursor, result data and cached end values
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_req    <= i_in_req;
            r_status <= ST_OK;
            r_data   <= '0;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.data_from_front) begin
            r_data <= r_front;
        end else if (i_cmd.data_from_back) begin
            r_data <= r_back;
        end else if (i_cmd.data_from_rd) begin
            r_data <= r_rdata;
        end
        if (i_cmd.cur_load_count) begin
            r_cur <= r_count;
        end else if (i_cmd.cur_load_pos) begin
            r_cur <= CNT_W'(r_req.position);
        end else if (i_cmd.cur_dec) begin
            r_cur <= r_cur - CNT_W'(1);
        end else if (i_cmd.cur_inc) begin
            r_cur <= r_cur + CNT_W'(1);
        end
        if (i_cmd.front_from_rd) begin
            r_front <= r_rdata;
        end
        if (i_cmd.back_from_rd) begin
            r_back <= r_rdata;
        end
        // Build the response; an empty list reports zero ends
        if (i_cmd.load_out) begin
            r_out.status      <= r_status;
            r_out.data_out    <= VAL_W'(r_data);
            r_out.count       <= OCNT_W'(r_count);
            r_out.front_value <= (r_count == '0) ? '0 : VAL_W'(r_front);
            r_out.back_value  <= (r_count == '0) ? '0 : VAL_W'(r_back);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

`default_nettype wire

FILE: design/rbd_controller.sv
// ============================================================================
// rbd_controller
// Sequencer that steps each request through its check and, as needed, read, shift and refresh phases.
// ============================================================================
`default_nettype none

module rbd_controller import rbd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_CAP,
        S_INS,
        S_INS_WR,
        S_REM_CAP,
        S_REM,
        S_REM_WR,
        S_RF_FRONT,
        S_RF_BACK,
        S_RF_CAP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;

    // Decode commands and next state
    always_comb begin
        o_cmd      = '0;
        o_cmd.status    = ST_OK;
        o_cmd.waddr_sel = AS_HEAD;
        o_cmd.raddr_sel = AS_HEAD;
        n_state    = r_state;
        n_in_stall = r_in_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_req = 1'b1;
                    n_in_stall      = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (i_stat.func)
                    FN_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.mem_we    = 1'b1;
                            o_cmd.waddr_sel = AS_HEAD_M1;
                            o_cmd.head_dec  = 1'b1;
                            o_cmd.cnt_inc   = 1'b1;
                            n_state         = S_RF_FRONT;
                        end
                    end
                    FN_PUSH_BACK: begin
                        if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.mem_we    = 1'b1;
                            o_cmd.waddr_sel = AS_COUNT;
                            o_cmd.cnt_inc   = 1'b1;
                            n_state         = S_RF_FRONT;
                        end
                    end
                    FN_POP_FRONT: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else begin
                            o_cmd.data_from_front = 1'b1;
                            o_cmd.head_inc        = 1'b1;
                            o_cmd.cnt_dec         = 1'b1;
                            n_state               = S_RF_FRONT;
                        end
                    end
                    FN_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else begin
                            o_cmd.data_from_back = 1'b1;
                            o_cmd.cnt_dec        = 1'b1;
                            n_state              = S_RF_FRONT;
                        end
                    end
                    FN_READ_AT: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else if (!i_stat.pos_lt_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else begin
                            o_cmd.raddr_sel = AS_POS;
                            n_state         = S_RD_CAP;
                        end
                    end
                    FN_INSERT_AT: begin
                        // Range check comes ahead of the full check
                        if (!i_stat.pos_le_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else if (i_stat.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_FULL;
                        end else begin
                            o_cmd.cur_load_count = 1'b1;
                            n_state              = S_INS;
                        end
                    end
                    FN_REMOVE_AT: begin
                        if (i_stat.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_EMPTY;
                        end else if (!i_stat.pos_lt_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = ST_RANGE;
                        end else begin
                            o_cmd.raddr_sel    = AS_POS;
                            o_cmd.cur_load_pos = 1'b1;
                            n_state            = S_REM_CAP;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_RD_CAP: begin
                o_cmd.data_from_rd = 1'b1;
                n_state            = S_DONE;
            end
            // Shift later elements up one place, back to front
            S_INS: begin
                if (i_stat.cur_gt_pos) begin
                    o_cmd.raddr_sel = AS_CUR_M1;
                    n_state         = S_INS_WR;
                end else begin
                    o_cmd.mem_we    = 1'b1;
                    o_cmd.waddr_sel = AS_POS;
                    o_cmd.cnt_inc   = 1'b1;
                    n_state         = S_RF_FRONT;
                end
            end
            S_INS_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_sel = AS_CUR;
                o_cmd.wdata_rd  = 1'b1;
                o_cmd.cur_dec   = 1'b1;
                n_state         = S_INS;
            end
            S_REM_CAP: begin
                o_cmd.data_from_rd = 1'b1;
                n_state            = S_REM;
            end
            // Shift later elements down one place, front to back
            S_REM: begin
                if (i_stat.cur_p1_lt_count) begin
                    o_cmd.raddr_sel = AS_CUR_P1;
                    n_state         = S_REM_WR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_RF_FRONT;
                end
            end
            S_REM_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.waddr_sel = AS_CUR;
                o_cmd.wdata_rd  = 1'b1;
                o_cmd.cur_inc   = 1'b1;
                n_state         = S_REM;
            end
            // Reload the cached front and back values
            S_RF_FRONT: begin
                if (i_stat.empty) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.raddr_sel = AS_HEAD;
                    n_state         = S_RF_BACK;
                end
            end
            S_RF_BACK: begin
                o_cmd.front_from_rd = 1'b1;
                o_cmd.raddr_sel     = AS_COUNT_M1;
                n_state             = S_RF_CAP;
            end
            S_RF_CAP: begin
                o_cmd.back_from_rd = 1'b1;
                n_state            = S_DONE;
            end
            // Hand the result over once the response register frees up
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_in_stall     = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_in_stall = 1'b0;
                n_state    = S_IDLE;
            end
        endcase
    end

    // Hold state and the input stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

`default_nettype wire

FILE: design/ring_buffer_deque.sv
// ============================================================================
// ring_buffer_deque
// Fixed-capacity double-ended list in a circular store, with indexed read,
// insert and remove.
// ============================================================================
//
//   Channel   Direction  Handshake               Payload
//   --------  ---------  ----------------------  -------------------------
//   request   in         i_in_valid / o_in_stall  i_in_req  (func, position, value)
//   response  out        o_out_valid / i_out_stall o_out_rsp (status, data_out,
//                                                   count, front/back value)
//
// One request at a time. Failed checks and unused codes go straight to the
// done state, and read_at adds one store read; successful pushes, pops,
// inserts and removes then reload the cached front and back values (skipped
// when the list ends up empty), and insert_at and remove_at first shift each
// later element one place, with one store read and one write per element.
// Reset is synchronous, active low, clears head, count and handshake state;
// the store itself is not cleared.
// A new request is taken while a finished response still waits under stall;
// the next result then holds in the done state until the response is taken.
// ============================================================================
`default_nettype none

module ring_buffer_deque import rbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_req,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;

    rbd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    rbd_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

`default_nettype wire

FILE: design/rbd_checker.sv
// ============================================================================
// rbd_assertions
// Port-level checks on the ring buffer deque, bound to the top level.
// ============================================================================
`default_nettype none

module rbd_assertions import rbd_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire t_req i_in_req,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_rsp o_out_rsp
);

    // Hold a stalled response
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_rsp)))
        else $error("stalled response changed");

    // Block further requests right after one is taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while busy");

    // Report zero ends for an empty list
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.count == '0)
            |-> (o_out_rsp.front_value == '0 && o_out_rsp.back_value == '0))
        else $error("empty list shows end values");

    // Refuse a push or insert only when the list is at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status == ST_FULL)
            |-> (o_out_rsp.count == OCNT_W'(CAPACITY)))
        else $error("full status below capacity");

    // Drop data on any failed request
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_rsp.status != ST_OK) |-> (o_out_rsp.data_out == '0))
        else $error("failed request returned data");

endmodule

bind ring_buffer_deque rbd_assertions u_rbd_assertions (.*);

`default_nettype wire

FILE: sim/rbd_checker.sv
// ============================================================================
// rbd_checker
// Watches both channels of the ring buffer deque, keeps its own copy of the
// list, and compares every response with the oldest predicted response.
// ============================================================================
`default_nettype none

module rbd_checker import rbd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire t_req        i_in_req,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire t_rsp        i_out_rsp,
    output int               o_fail_count,
    output int               o_pending,
    output logic [CNT_W-1:0] o_depth
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow list: circular slots, head and element count
    logic [VAL_W-1:0] slots [CAPACITY];
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] held;

    // Responses owed by the block, oldest first
    t_rsp owed_rsp [$];
    t_rsp want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_depth      = '0;
        head         = '0;
        held         = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0d ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string field, input logic [VAL_W-1:0] got,
                               input logic [VAL_W-1:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s is %h, expected %h", field, got, exp_val));
        end
    endtask

    // Physical slot of a logical position counted from the front
    function automatic logic [IDX_W-1:0] slot_at(input int unsigned offs);
        return IDX_W'(head + offs);
    endfunction

    // Apply one request to the shadow list and build the response it earns
    function automatic t_rsp apply_deque_op(input t_req r);
        t_rsp        rsp;
        int unsigned k;
        rsp        = '0;
        rsp.status = ST_OK;
        case (r.func)
            FN_PUSH_FRONT: begin
                if (held == CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    head        = head - 1'b1;
                    slots[head] = r.value;
                    held        = held + 1'b1;
                end
            end
            FN_PUSH_BACK: begin
                if (held == CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    slots[slot_at(held)] = r.value;
                    held                 = held + 1'b1;
                end
            end
            FN_POP_FRONT: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.data_out = slots[head];
                    head         = head + 1'b1;
                    held         = held - 1'b1;
                end
            end
            FN_POP_BACK: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.data_out = slots[slot_at(held - 1)];
                    held         = held - 1'b1;
                end
            end
            FN_READ_AT: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (r.position >= held) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.data_out = slots[slot_at(r.position)];
                end
            end
            FN_INSERT_AT: begin
                // Range check wins over the full check
                if (r.position > held) begin
                    rsp.status = ST_RANGE;
                end else if (held == CAPACITY) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (k = held; k > r.position; k--) begin
                        slots[slot_at(k)] = slots[slot_at(k - 1)];
                    end
                    slots[slot_at(r.position)] = r.value;
                    held = held + 1'b1;
                end
            end
            FN_REMOVE_AT: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (r.position >= held) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.data_out = slots[slot_at(r.position)];
                    for (k = r.position; k + 1 < held; k++) begin
                        slots[slot_at(k)] = slots[slot_at(k + 1)];
                    end
                    held = held - 1'b1;
                end
            end
            default: begin
                // Unused code: leave the list alone
            end
        endcase
        rsp.count = OCNT_W'(held);
        if (held != 0) begin
            rsp.front_value = slots[head];
            rsp.back_value  = slots[slot_at(held - 1)];
        end
        return rsp;
    endfunction

    // Check responses and predict requests on every accepted handshake
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head = '0;
            held = '0;
            owed_rsp.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (owed_rsp.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = owed_rsp.pop_front();
                    check_field("status", VAL_W'(i_out_rsp.status), VAL_W'(want.status));
                    check_field("data_out", i_out_rsp.data_out, want.data_out);
                    check_field("count", VAL_W'(i_out_rsp.count), VAL_W'(want.count));
                    check_field("front_value", i_out_rsp.front_value, want.front_value);
                    check_field("back_value", i_out_rsp.back_value, want.back_value);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                owed_rsp.push_back(apply_deque_op(i_in_req));
            end
        end
        o_pending = owed_rsp.size();
        o_depth  <= held;
    end

endmodule

`default_nettype wire

FILE: sim/tb_ring_buffer_deque.sv
// ============================================================================
// tb_ring_buffer_deque
// Drives directed and random deque requests into the ring buffer deque with
// random idling on both channels; the checker beside the block does the
// prediction and comparison, and this module gives the verdict.
// ============================================================================
`default_nettype none

module tb_ring_buffer_deque;
    timeunit 1ns;
    timeprecision 1ps;

    import rbd_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 170;
    localparam int DRAIN_CYCLES = 64;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_req    = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_rsp out_rsp;

    int               in_idle_pct  = 0;
    int               out_idle_pct = 0;
    int               fail_count;
    int               pending;
    logic [CNT_W-1:0] depth;
    bit               growing = 1'b1;

    always #5 clk = ~clk;

    // Receiver stall, redrawn every cycle
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    ring_buffer_deque dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    rbd_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_rsp    (out_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_depth      (depth)
    );

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{func: fn, position: pos, value: val};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Hold off the sender until every owed response has come back
    task automatic drain_wait();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed traffic that sweeps the list from empty to full and
    // back; a tenth is raw noise over every code and position
    task automatic send_random();
        logic [FUNC_W-1:0] fn;
        logic [POS_W-1:0]  pos;
        int unsigned       d;
        d = 32'(depth);
        if (d >= CAPACITY) begin
            growing = 1'b0;
        end else if (d == 0) begin
            growing = 1'b1;
        end
        pos = '0;
        if ($urandom_range(99) < 10) begin
            fn  = FUNC_W'($urandom_range(7));
            pos = POS_W'($urandom_range(31));
        end else if (growing) begin
            case ($urandom_range(5))
                0:       fn = FN_PUSH_FRONT;
                1:       fn = FN_PUSH_BACK;
                2, 3: begin
                    fn  = FN_INSERT_AT;
                    pos = POS_W'($urandom_range(d, 0));
                end
                4: begin
                    fn  = FN_READ_AT;
                    pos = POS_W'($urandom_range(d, 0));
                end
                default: fn = FN_POP_BACK;
            endcase
        end else begin
            case ($urandom_range(5))
                0:       fn = FN_POP_FRONT;
                1:       fn = FN_POP_BACK;
                2, 3: begin
                    fn  = FN_REMOVE_AT;
                    pos = POS_W'($urandom_range((d > 0) ? d - 1 : 0, 0));
                end
                4: begin
                    fn  = FN_READ_AT;
                    pos = POS_W'($urandom_range(d, 0));
                end
                default: fn = FN_PUSH_BACK;
            endcase
        end
        send_req(fn, pos, rand_value());
    endtask

    initial begin
        int ph;
        int n;
        int i;

        in_idle_pct  = 18;
        out_idle_pct = 84;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: every failing access, bad insert position, unused code
        send_req(FN_POP_FRONT, 5'd0, '1);
        send_req(FN_POP_BACK, 5'd0, '0);
        send_req(FN_READ_AT, 5'd0, '0);
        send_req(FN_REMOVE_AT, 5'd0, '0);
        send_req(FN_INSERT_AT, 5'd1, 32'h1234_5678);
        send_req(FN_UNUSED, 5'h1f, '1);

        // Small list: end operations, reads in and out of range, middle edits
        send_req(FN_INSERT_AT, 5'd0, '1);
        send_req(FN_PUSH_FRONT, 5'd0, '0);
        send_req(FN_PUSH_BACK, 5'd0, 32'hA5A5_5A5A);
        send_req(FN_READ_AT, 5'd2, '0);
        send_req(FN_READ_AT, 5'd3, '0);
        send_req(FN_READ_AT, 5'h1f, '0);
        send_req(FN_REMOVE_AT, 5'd3, '0);
        send_req(FN_INSERT_AT, 5'd3, 32'h0000_0001);
        send_req(FN_INSERT_AT, 5'd1, 32'h8000_0000);
        send_req(FN_REMOVE_AT, 5'd2, '0);
        send_req(FN_UNUSED, 5'd0, '0);

        // Fill to capacity from both ends so the head wraps
        for (i = 4; i < CAPACITY; i++) begin
            send_req((i % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK, 5'd0, $urandom);
        end

        // Full list: refused pushes, range before full, longest shifts
        send_req(FN_PUSH_FRONT, 5'd0, '1);
        send_req(FN_PUSH_BACK, 5'd0, '1);
        send_req(FN_INSERT_AT, 5'd16, '1);
        send_req(FN_INSERT_AT, 5'd17, '1);
        send_req(FN_INSERT_AT, 5'd0, '1);
        send_req(FN_READ_AT, 5'd15, '0);
        send_req(FN_REMOVE_AT, 5'd0, '0);
        send_req(FN_INSERT_AT, 5'd0, 32'h7FFF_FFFE);
        send_req(FN_REMOVE_AT, 5'd15, '0);
        send_req(FN_POP_FRONT, 5'd0, '0);
        send_req(FN_POP_BACK, 5'd0, '0);
        drain_wait();

        // Random traffic under three idling mixes
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct  = 18;
                    out_idle_pct = 84;
                end
                1: begin
                    in_idle_pct  = 84;
                    out_idle_pct = 18;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
                if ($urandom_range(59) == 0) begin
                    drain_wait();
                end
            end
            drain_wait();
        end

        // Let any trailing work show up, then give the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
design/rbd_pkg.sv
design/rbd_datapath.sv
design/rbd_controller.sv
design/ring_buffer_deque.sv
design/rbd_checker.sv
sim/rbd_checker.sv
sim/tb_ring_buffer_deque.sv
